// ===== rtl/core/bpg_pkg.sv =====
// ----------------------------------------------------------------------------
// bpg_pkg: balanced parenthesis generator package
// Widths, microcode step addresses, control word type and the control store.
// ----------------------------------------------------------------------------
package bpg_pkg;

  localparam int MAX_PAIRS = 16;
  localparam int PAIRS_W   = 5;
  localparam int PAT_W     = 32;
  localparam int POS_W     = 5;
  localparam int J_W       = POS_W + 1;
  localparam int K_W       = POS_W + 2;
  localparam int STEP_W    = 4;

  // microcode step addresses
  localparam logic [STEP_W-1:0] P_FETCH  = 4'd0;
  localparam logic [STEP_W-1:0] P_RST    = 4'd1;
  localparam logic [STEP_W-1:0] P_NULL   = 4'd2;
  localparam logic [STEP_W-1:0] P_ADV    = 4'd3;
  localparam logic [STEP_W-1:0] P_INIT   = 4'd4;
  localparam logic [STEP_W-1:0] P_SCAN   = 4'd5;
  localparam logic [STEP_W-1:0] P_FINISH = 4'd6;
  localparam logic [STEP_W-1:0] P_SHORT  = 4'd7;
  localparam logic [STEP_W-1:0] P_EMIT   = 4'd8;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_FIRST,
    OP_NULL,
    OP_SET_M,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_FINISH,
    OP_SHORT,
    OP_EMIT
  } op_t;

  // sequencer jump conditions
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_DISPATCH,
    JC_IF_SHORT,
    JC_WHILE_SCAN,
    JC_WAIT_OUT
  } jc_t;

  typedef struct packed {
    op_t               op;
    jc_t               jc;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // control store
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    case (pc)
      P_FETCH:  w = '{op: OP_NONE,       jc: JC_DISPATCH,   target: P_FETCH};
      P_RST:    w = '{op: OP_LOAD_FIRST, jc: JC_GOTO,       target: P_EMIT};
      P_NULL:   w = '{op: OP_NULL,       jc: JC_GOTO,       target: P_EMIT};
      P_ADV:    w = '{op: OP_SET_M,      jc: JC_IF_SHORT,   target: P_SHORT};
      P_INIT:   w = '{op: OP_SCAN_INIT,  jc: JC_NEXT,       target: P_SCAN};
      P_SCAN:   w = '{op: OP_SCAN,       jc: JC_WHILE_SCAN, target: P_SCAN};
      P_FINISH: w = '{op: OP_FINISH,     jc: JC_GOTO,       target: P_EMIT};
      P_SHORT:  w = '{op: OP_SHORT,      jc: JC_GOTO,       target: P_EMIT};
      P_EMIT:   w = '{op: OP_EMIT,       jc: JC_WAIT_OUT,   target: P_FETCH};
      default:  w = '{op: OP_NONE,       jc: JC_GOTO,       target: P_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/bpg_in_if.sv =====
// ----------------------------------------------------------------------------
// bpg_in_if: request channel
// Valid/ready channel carrying the restart flag of one request.
// ----------------------------------------------------------------------------
interface bpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== rtl/core/bpg_out_if.sv =====
// ----------------------------------------------------------------------------
// bpg_out_if: result channel
// Valid/ready channel carrying one generated string and its flags.
// ----------------------------------------------------------------------------
interface bpg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pattern;
  logic        last;
  logic        valid_res;

  modport source (output valid, output pattern, output last, output valid_res,
                  input ready);
  modport sink (input valid, input pattern, input last, input valid_res,
                output ready);
endinterface

// ===== rtl/core/balanced_paren_generator_top.sv =====
// ----------------------------------------------------------------------------
// balanced_paren_generator_top: balanced parenthesis string generator
// Steps: a restart or exhausted request runs fetch, then load or null, then
// emit; an advance runs fetch and set-m, then short and emit, or scan init,
// scan steps that walk back over the run of open parens, finish and emit.
// Emit waits until the output register is free. One transaction in flight;
// the next request is taken once the result is registered.
// Reset: sequencer at fetch, generator exhausted (awaiting restart), pairs = 2.
// ----------------------------------------------------------------------------
module balanced_paren_generator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bpg_pkg::PAIRS_W-1:0]  cfg_data,
  bpg_in_if.sink                       in_ch,
  bpg_out_if.source                    out_ch
);
  import bpg_pkg::*;

  // configuration and sequencer
  logic [PAIRS_W-1:0] pairs;
  logic [STEP_W-1:0]  pc;
  logic [STEP_W-1:0]  pc_next;
  ctrl_t              ctrl;

  // datapath state
  logic [PAT_W-1:0]   s;
  logic [POS_W-1:0]   m;
  logic [POS_W-1:0]   top;
  logic               exhausted;
  logic signed [J_W-1:0] j;
  logic signed [K_W-1:0] k;

  // staged result
  logic [PAT_W-1:0]   res_pattern;
  logic               res_last;
  logic               res_valid;

  // output register
  logic               out_valid;
  logic [PAT_W-1:0]   out_pattern;
  logic               out_last;
  logic               out_valid_res;

  logic               short_cond;
  logic               scan_go;
  logic               emit_go;
  logic [PAIRS_W-1:0] n_clamp;
  logic [POS_W-1:0]   m_dec;
  logic [PAT_W-1:0]   first_str;

  assign ctrl = ucode(pc);

  // condition signals
  assign m_dec      = m - POS_W'(1);
  assign short_cond = (m != '0) && s[m_dec];
  assign scan_go    = (j >= 0) && !s[j[POS_W-1:0]];
  assign emit_go    = !out_valid || out_ch.ready;

  // pair count clamp and first string
  always_comb begin
    if (pairs < PAIRS_W'(2)) begin
      n_clamp = PAIRS_W'(2);
    end else if (pairs > PAIRS_W'(MAX_PAIRS)) begin
      n_clamp = PAIRS_W'(MAX_PAIRS);
    end else begin
      n_clamp = pairs;
    end
    first_str = '0;
    for (int i = 0; i < MAX_PAIRS; i++) begin
      first_str[2*i+1] = (PAIRS_W'(i) < n_clamp);
    end
  end

  // next step
  always_comb begin
    pc_next = pc + STEP_W'(1);
    case (ctrl.jc)
      JC_NEXT:       pc_next = pc + STEP_W'(1);
      JC_GOTO:       pc_next = ctrl.target;
      JC_DISPATCH: begin
        if (!in_ch.valid) begin
          pc_next = pc;
        end else if (in_ch.restart) begin
          pc_next = P_RST;
        end else if (exhausted) begin
          pc_next = P_NULL;
        end else begin
          pc_next = P_ADV;
        end
      end
      JC_IF_SHORT:   pc_next = short_cond ? ctrl.target : pc + STEP_W'(1);
      JC_WHILE_SCAN: pc_next = scan_go ? ctrl.target : pc + STEP_W'(1);
      JC_WAIT_OUT:   pc_next = emit_go ? ctrl.target : pc;
      default:       pc_next = P_FETCH;
    endcase
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= P_FETCH;
      pairs     <= PAIRS_W'(2);
      exhausted <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        pairs <= cfg_data;
      end
      case (ctrl.op)
        OP_LOAD_FIRST: exhausted <= 1'b0;
        OP_FINISH:     if (j < 0) exhausted <= 1'b1;
        default:       ;
      endcase
      if (ctrl.op == OP_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      s <= '0;
      m <= '0;
    end else begin
      case (ctrl.op)
        OP_LOAD_FIRST: begin
          s           <= first_str;
          m           <= POS_W'({n_clamp, 1'b0} - 6'd2);
          top         <= POS_W'({n_clamp, 1'b0} - 6'd2);
          res_pattern <= '0;
          res_last    <= 1'b0;
          res_valid   <= 1'b0;
        end
        OP_NULL: begin
          res_pattern <= '0;
          res_last    <= 1'b0;
          res_valid   <= 1'b0;
        end
        OP_SET_M: begin
          res_pattern <= s;
          res_last    <= 1'b0;
          res_valid   <= 1'b1;
          s[m]        <= 1'b1;
        end
        OP_SHORT: begin
          m        <= m_dec;
          s[m_dec] <= 1'b0;
        end
        OP_SCAN_INIT: begin
          j <= J_W'(signed'({1'b0, m})) - J_W'(1);
          k <= K_W'(signed'({2'b0, top}));
        end
        OP_SCAN: begin
          if (scan_go) begin
            s[j[POS_W-1:0]] <= 1'b1;
            if (k >= 0) begin
              s[k[POS_W-1:0]] <= 1'b0;
            end
            j <= j - J_W'(1);
            k <= k - K_W'(2);
          end
        end
        OP_FINISH: begin
          if (j < 0) begin
            res_last <= 1'b1;
          end else begin
            s[j[POS_W-1:0]] <= 1'b0;
            m               <= top;
          end
        end
        default: ;
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && emit_go) begin
      out_pattern   <= res_pattern;
      out_last      <= res_last;
      out_valid_res <= res_valid;
    end
  end

  assign in_ch.ready      = (ctrl.jc == JC_DISPATCH);
  assign out_ch.valid     = out_valid;
  assign out_ch.pattern   = out_pattern;
  assign out_ch.last      = out_last;
  assign out_ch.valid_res = out_valid_res;

endmodule

// ===== test/balanced_paren_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balanced_paren_generator_top_tb: testbench for the balanced paren generator
// Drives restart and advance requests, with pair counts written between
// phases, and checks every generated string and its flags against a cycle-free
// model of the enumeration. Both channels stall at random, and once the
// result side holds off for a long stretch.
// ----------------------------------------------------------------------------
module balanced_paren_generator_top_tb;
  import bpg_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_PRINTS    = 40;
  localparam int TIMEOUT_CYCLES = 1500000;

  // request codes
  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic             last;
    logic             valid_res;
  } paren_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [PAIRS_W-1:0] cfg_data = '0;

  bpg_in_if  in_ch ();
  bpg_out_if out_ch ();

  balanced_paren_generator_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_we),
    .cfg_data (cfg_data),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // requests waiting to be sent and strings waiting to come back
  logic       request_q[$];
  paren_res_t strings_due[$];
  int         queued_cnt = 0;
  int         mismatch_cnt = 0;

  // idling control
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done;
  int   hold_left;

  // generator state as the model sees it
  logic [PAIRS_W-1:0] gen_pairs_cfg;
  int                 gen_pairs;
  logic [PAT_W-1:0]   gen_string;
  int                 gen_change_pos;
  logic               gen_done;

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic flag_mismatch(input string what, input logic [PAT_W-1:0] got,
                               input logic [PAT_W-1:0] want);
    if (mismatch_cnt < MAX_PRINTS)
      $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // one request in, one string out; walks the successor search back over opens
  task automatic next_paren_string(input logic restart_i);
    paren_res_t       res;
    logic [PAT_W-1:0] s;
    int               n, m, j, k, top;
    res = '0;
    if (restart_i == REQ_RESTART) begin
      n = gen_pairs_cfg;
      if (n < 2) n = 2;
      if (n > MAX_PAIRS) n = MAX_PAIRS;
      gen_pairs = n;
      gen_string = '0;
      for (int i = 0; i < n; i++) gen_string[2 * i + 1] = 1'b1;
      gen_change_pos = 2 * n - 2;
      gen_done = 1'b0;
    end else if (!gen_done) begin
      res.pattern = gen_string;
      res.valid_res = 1'b1;
      s = gen_string;
      m = gen_change_pos;
      top = 2 * gen_pairs - 2;
      s[m] = 1'b1;
      if (m >= 1 && s[m - 1]) begin
        // short path: swap with the close paren just before
        m = m - 1;
        s[m] = 1'b0;
        gen_string = s;
        gen_change_pos = m;
      end else begin
        j = m - 1;
        k = top;
        while (j >= 0 && !s[j]) begin
          s[j] = 1'b1;
          if (k >= 0) s[k] = 1'b0;
          j = j - 1;
          k = k - 2;
        end
        gen_string = s;
        if (j < 0) begin
          gen_done = 1'b1;
          res.last = 1'b1;
        end else begin
          gen_string[j] = 1'b0;
          gen_change_pos = top;
        end
      end
    end
    strings_due.push_back(res);
  endtask

  // model update on config writes and accepted requests
  always @(posedge clk) begin
    if (rst) begin
      gen_pairs_cfg = 5'd2;
      gen_pairs = 2;
      gen_string = '0;
      gen_change_pos = 0;
      gen_done = 1'b1;
    end else begin
      if (cfg_we) gen_pairs_cfg = cfg_data;
      if (in_ch.valid && in_ch.ready) next_paren_string(in_ch.restart);
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.restart <= REQ_ADVANCE;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (request_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.restart <= request_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    paren_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (strings_due.size() == 0) begin
        flag_mismatch("unexpected transaction", out_ch.pattern, '0);
      end else begin
        want = strings_due.pop_front();
        if (out_ch.pattern !== want.pattern)
          flag_mismatch("pattern", out_ch.pattern, want.pattern);
        if (out_ch.last !== want.last)
          flag_mismatch("last", PAT_W'(out_ch.last), PAT_W'(want.last));
        if (out_ch.valid_res !== want.valid_res)
          flag_mismatch("valid_res", PAT_W'(out_ch.valid_res), PAT_W'(want.valid_res));
      end
    end
  end

  task automatic queue_request(input logic r);
    request_q.push_back(r);
    queued_cnt++;
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    do @(posedge clk);
    while (request_q.size() != 0 || in_ch.valid || strings_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pairs(input logic [PAIRS_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // stimulus
  initial begin
    int random_start, sel, eff, full_len, run_len;
    logic [PAIRS_W-1:0] cfg_v;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_idling(8, 55);

    // advance before any restart, then the default two-pair run to exhaustion
    queue_request(REQ_ADVANCE);
    queue_request(REQ_RESTART);
    repeat (3) queue_request(REQ_ADVANCE);
    wait_drained();

    // all config bits high: clamped to the largest pair count
    write_pairs(5'd31);
    queue_request(REQ_RESTART);
    repeat (3) queue_request(REQ_ADVANCE);
    wait_drained();

    // all config bits low: clamped to two pairs
    write_pairs(5'd0);
    queue_request(REQ_RESTART);
    repeat (3) queue_request(REQ_ADVANCE);
    wait_drained();

    // config change mid-run has no effect until the next restart
    write_pairs(5'd3);
    queue_request(REQ_RESTART);
    repeat (2) queue_request(REQ_ADVANCE);
    wait_drained();
    write_pairs(5'd17);
    repeat (4) queue_request(REQ_ADVANCE);
    // restart in the middle of an enumeration
    queue_request(REQ_RESTART);
    queue_request(REQ_ADVANCE);
    queue_request(REQ_RESTART);
    queue_request(REQ_ADVANCE);
    wait_drained();

    // random phases of mostly well-formed runs
    random_start = queued_cnt;
    while (queued_cnt - random_start < RANDOM_ITEMS) begin
      if (queued_cnt - random_start < RANDOM_ITEMS / 3) begin
        set_idling(8, 55);
      end else if (queued_cnt - random_start < 2 * RANDOM_ITEMS / 3) begin
        set_idling(55, 8);
      end else begin
        set_idling(0, 0);
      end

      sel = $urandom_range(99, 0);
      if (sel < 60) cfg_v = PAIRS_W'($urandom_range(5, 2));
      else if (sel < 70) cfg_v = PAIRS_W'($urandom_range(1, 0));
      else if (sel < 74) cfg_v = 5'd6;
      else cfg_v = PAIRS_W'($urandom_range(31, 7));
      write_pairs(cfg_v);

      eff = (cfg_v < 2) ? 2 : ((cfg_v > MAX_PAIRS) ? MAX_PAIRS : int'(cfg_v));
      case (eff)
        2: full_len = 2;
        3: full_len = 5;
        4: full_len = 14;
        5: full_len = 42;
        6: full_len = 132;
        default: full_len = 0;
      endcase
      if (full_len != 0 && $urandom_range(3, 0) != 0)
        run_len = full_len + $urandom_range(3, 0);
      else
        run_len = $urandom_range(40, 1);

      // long receiver hold-off while requests keep coming
      if (!hold_req && queued_cnt - random_start >= 300) hold_req <= 1'b1;

      if ($urandom_range(9, 0) != 0) queue_request(REQ_RESTART);
      repeat (run_len) begin
        if ($urandom_range(99, 0) < 4) queue_request(logic'($urandom_range(1, 0)));
        else queue_request(REQ_ADVANCE);
      end
      wait_drained();
    end

    // leftover strings never came back
    while (strings_due.size() != 0) begin
      void'(strings_due.pop_front());
      flag_mismatch("missing transaction", '0, '0);
    end

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
